>>> src/gas_pkg.sv
// Shared types and constants for the graph adjacency store.
package gas_pkg;

	localparam int MaxVertices = 32;
	localparam int VertexW     = 5;
	localparam int VertexCount = 1 << VertexW;
	localparam int CountW      = 6;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TEST   = 2'd2,
		OP_LIST   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK     = 3'd0,
		STAT_RANGE  = 3'd1,
		STAT_SELF   = 3'd2,
		STAT_EXISTS = 3'd3,
		STAT_ABSENT = 3'd4
	} status_t;

	// One adjacency row with its neighbor count.
	typedef struct packed {
		logic [CountW-1:0]      count;
		logic [VertexCount-1:0] row;
	} gas_row_t;

	// Request bundle into the row memory.
	typedef struct packed {
		logic               rd_en;
		logic [VertexW-1:0] rd_addr;
		logic               wr_en;
		logic [VertexW-1:0] wr_addr;
		gas_row_t           wr_data;
		logic               clear;
	} gas_ram_req_t;

endpackage

>>> src/gas_row_ram.sv
// Adjacency row memory with per-row valid bits and a registered read port.
module gas_row_ram
	import gas_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  gas_ram_req_t req,
	output gas_row_t     rd_data
);

	gas_row_t               mem [VertexCount];
	logic [VertexCount-1:0] valid_q;
	gas_row_t               rd_row_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_row_q <= mem[req.rd_addr];
		end
	end

	// Drop every row at once on clear; a row not yet written reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_row_q : '0;

endmodule

>>> src/graph_adjacency_store.sv
// Top level of the graph adjacency store: request sequencer and register port.
//
// Holds a graph of up to 32 vertices as one adjacency bitmap row per vertex,
// with the row's neighbor count, in a single synchronous row memory. Each
// request adds, removes or tests an edge, or lists a vertex's out-neighbors in
// ascending order, one result transfer per neighbor. Requests are taken one at
// a time. Add, remove, test and every rejected request are accepted, then read
// the source row from the registered read port; an undirected add or remove
// that succeeds then sends the mirror row through a second read-modify-write on
// the same memory port; a listing reads the row, then the single-entry output
// register emits one neighbor a cycle while out_ready is high. A result waiting
// with out_ready low stalls the sequencer. Writing either register through
// the APB port clears every edge at once through per-row valid bits, so no
// clearing pass follows reset or reconfiguration. Write registers only while
// no request is in flight.
module graph_adjacency_store
	import gas_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [VertexW-1:0] src_vertex,
	input  logic [VertexW-1:0] dst_vertex,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic               edge_present,
	output logic               neighbor_valid,
	output logic [VertexW-1:0] neighbor_vertex,
	output logic [VertexW-1:0] neighbor_total,
	output logic               last,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD_F,
		S_RD_T,
		S_LIST
	} state_t;

	typedef enum logic {
		REG_ACTIVE = 1'b0,
		REG_UNDIR  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		status_t            status;
		logic               edge_present;
		logic               neighbor_valid;
		logic [VertexW-1:0] neighbor_vertex;
		logic [VertexW-1:0] neighbor_total;
		logic               last;
	} result_t;

	// Index of the single set bit of a one-hot row.
	function automatic logic [VertexW-1:0] onehot_index(input logic [VertexCount-1:0] oh);
		logic [VertexW-1:0] idx;
		idx = '0;
		for (int i = 0; i < VertexCount; i++) begin
			if (oh[i]) begin
				idx = idx | VertexW'(i);
			end
		end
		return idx;
	endfunction

	state_t                 state_q, nxt_state;
	logic [CountW-1:0]      active_q;
	logic                   undir_q;
	op_t                    op_q;
	logic [VertexW-1:0]     from_q, to_q;
	logic                   err_q;
	status_t                err_code_q;
	logic [VertexCount-1:0] list_row_q;
	logic [VertexW-1:0]     list_total_q;
	logic                   out_valid_q;
	result_t                out_q, res;
	logic                   emit;
	logic                   slot_free;
	logic                   cfg_wr;
	reg_idx_t               cfg_idx;
	logic [CountW-1:0]      lim;
	logic                   from_oor, to_oor;
	gas_ram_req_t           ram_req;
	gas_row_t               rd_row;
	gas_row_t               upd_row;
	logic [VertexCount-1:0] low_bit, rest_row;

	// ---------------------------------------------------------------- config
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		case (cfg_idx)
			REG_ACTIVE: prdata = {{(32-CountW){1'b0}}, active_q};
			REG_UNDIR:  prdata = {31'b0, undir_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			undir_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ACTIVE: active_q <= pwdata[CountW-1:0];
				REG_UNDIR:  undir_q  <= pwdata[0];
				default:    ;
			endcase
		end
	end

	// A vertex count above the store's capacity acts as the capacity.
	assign lim      = (active_q > CountW'(MaxVertices)) ? CountW'(MaxVertices) : active_q;
	assign from_oor = {1'b0, src_vertex} >= lim;
	assign to_oor   = {1'b0, dst_vertex} >= lim;

	// ---------------------------------------------------------------- memory
	gas_row_ram u_rows (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.rd_data (rd_row)
	);

	// Lowest remaining neighbor of the row under listing.
	assign low_bit  = list_row_q & (~list_row_q + VertexCount'(1));
	assign rest_row = list_row_q & ~low_bit;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		nxt_state       = state_q;
		emit            = 1'b0;
		res             = '0;
		res.status      = STAT_OK;
		res.last        = 1'b1;
		ram_req         = '0;
		ram_req.clear   = cfg_wr;
		upd_row         = rd_row;
		case (state_q)
			S_IDLE: begin
				// Start the source row read as the request transfers.
				if (in_valid) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = src_vertex;
					nxt_state       = S_RD_F;
				end
			end
			S_RD_F: begin
				// Hold the read data until the output slot frees up.
				if (slot_free) begin
					emit      = 1'b1;
					nxt_state = S_IDLE;
					if (err_q) begin
						res.status = err_code_q;
					end else begin
						case (op_q)
							OP_TEST: begin
								res.edge_present = rd_row.row[to_q];
							end
							OP_ADD: begin
								if (rd_row.row[to_q]) begin
									res.status = STAT_EXISTS;
								end else begin
									upd_row.row[to_q] = 1'b1;
									upd_row.count     = rd_row.count + CountW'(1);
									ram_req.wr_en     = 1'b1;
									ram_req.wr_addr   = from_q;
									ram_req.wr_data   = upd_row;
								end
							end
							OP_REMOVE: begin
								if (!rd_row.row[to_q]) begin
									res.status = STAT_ABSENT;
								end else begin
									upd_row.row[to_q] = 1'b0;
									upd_row.count     = rd_row.count - CountW'(1);
									ram_req.wr_en     = 1'b1;
									ram_req.wr_addr   = from_q;
									ram_req.wr_data   = upd_row;
								end
							end
							OP_LIST: begin
								if (rd_row.row != '0) begin
									emit      = 1'b0;
									nxt_state = S_LIST;
								end
							end
							default: ;
						endcase
						// Mirror edge: read the reverse row while the source row is written.
						if (undir_q && ram_req.wr_en) begin
							emit            = 1'b0;
							ram_req.rd_en   = 1'b1;
							ram_req.rd_addr = to_q;
							nxt_state       = S_RD_T;
						end
					end
				end
			end
			S_RD_T: begin
				if (slot_free) begin
					emit      = 1'b1;
					nxt_state = S_IDLE;
					if (op_q == OP_ADD && !rd_row.row[from_q]) begin
						upd_row.row[from_q] = 1'b1;
						upd_row.count       = rd_row.count + CountW'(1);
						ram_req.wr_en       = 1'b1;
					end else if (op_q == OP_REMOVE && rd_row.row[from_q]) begin
						upd_row.row[from_q] = 1'b0;
						upd_row.count       = rd_row.count - CountW'(1);
						ram_req.wr_en       = 1'b1;
					end
					ram_req.wr_addr = to_q;
					ram_req.wr_data = upd_row;
				end
			end
			S_LIST: begin
				if (slot_free) begin
					emit                = 1'b1;
					res.neighbor_valid  = 1'b1;
					res.neighbor_vertex = onehot_index(low_bit);
					res.neighbor_total  = list_total_q;
					res.last            = (rest_row == '0);
					if (rest_row == '0) begin
						nxt_state = S_IDLE;
					end
				end
			end
			default: nxt_state = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			op_q         <= OP_ADD;
			from_q       <= '0;
			to_q         <= '0;
			err_q        <= 1'b0;
			err_code_q   <= STAT_OK;
			list_row_q   <= '0;
			list_total_q <= '0;
		end else begin
			state_q <= nxt_state;
			if (emit) begin
				out_valid_q <= 1'b1;
				out_q       <= res;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// Latch the request and its range and self-loop checks on transfer.
			if (state_q == S_IDLE && in_valid) begin
				op_q   <= op_t'(op);
				from_q <= src_vertex;
				to_q   <= dst_vertex;
				if (op_t'(op) == OP_LIST) begin
					err_q      <= from_oor;
					err_code_q <= STAT_RANGE;
				end else if (from_oor || to_oor) begin
					err_q      <= 1'b1;
					err_code_q <= STAT_RANGE;
				end else begin
					err_q      <= (src_vertex == dst_vertex);
					err_code_q <= STAT_SELF;
				end
			end
			if (state_q == S_RD_F && nxt_state == S_LIST) begin
				list_row_q   <= rd_row.row;
				list_total_q <= rd_row.count[VertexW-1:0];
			end else if (state_q == S_LIST && emit) begin
				list_row_q <= rest_row;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign edge_present    = out_q.edge_present;
	assign neighbor_valid  = out_q.neighbor_valid;
	assign neighbor_vertex = out_q.neighbor_vertex;
	assign neighbor_total  = out_q.neighbor_total;
	assign last            = out_q.last;

	// ---------------------------------------------------------------- checks
	// A write and a read of the same row never overlap in one cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.wr_en && ram_req.rd_en |-> ram_req.wr_addr != ram_req.rd_addr)
		else $error("row write and read hit the same entry");

	// Only a listing emits a result that is not the last of its request.
	a_mid_is_neighbor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> neighbor_valid && status == STAT_OK)
		else $error("non-final result outside a listing");

	// A listed neighbor always comes with a nonzero total.
	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && neighbor_valid |-> neighbor_total != '0)
		else $error("listed neighbor with zero total");

	// Requests are handled one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in flight");

endmodule
